// ----- rtl/core/itoa_pkg.sv -----
package itoa_pkg;

   // Default width of the converted integer.
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Radix register.
   localparam int RADIX_W = 6;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] DECIMAL_BASE = 6'd10;

   // Character codes.
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Dividend bits retired per divider cycle.
   localparam int DIV_STEPS = 8;

   // Entries in the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Back end sequencer.
   typedef enum logic [1:0] {
      B_IDLE,
      B_DIVIDE,
      B_SIGN,
      B_EMIT
   } back_state_type;

   // Maps a digit value 0..35 to '0'..'9' or 'a'..'z'.
   function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [7:0] code;
      if (d > 6'd9) begin
         code = {2'b00, d} + (CHAR_LOWER_A - 8'd10);
      end else begin
         code = {2'b00, d} + CHAR_ZERO;
      end
      return code;
   endfunction

endpackage

// ----- rtl/core/itoa_queue.sv -----
module itoa_queue
   import itoa_pkg::*;
#(
   parameter int WIDTH = 39
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count updates; pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/itoa_front.sv -----
module itoa_front
   import itoa_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [VALUE_WIDTH-1:0]           req_value,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [RADIX_W-1:0]               csr_radix,
   output logic                             push,
   output logic [VALUE_WIDTH+RADIX_W:0]     push_data,
   input  logic                             full
);

   logic [RADIX_W-1:0]     radix_ff;
   logic [RADIX_W-1:0]     base;
   logic                   negative;
   logic [VALUE_WIDTH-1:0] magnitude;

   // The radix register takes a write in any cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_valid && csr_ready) begin
         radix_ff <= csr_radix;
      end
   end

   // Out-of-range radix values clamp to the nearest legal base.
   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         base = RADIX_MAX;
      end else begin
         base = radix_ff;
      end
   end

   // Only base ten reads the value as signed; other bases see an unsigned word.
   assign negative  = (base == DECIMAL_BASE) && req_value[VALUE_WIDTH-1];
   assign magnitude = negative ? (~req_value + 1'b1) : req_value;

   assign busy      = full;
   assign push      = start && !full;
   assign push_data = {magnitude, negative, base};

endmodule

// ----- rtl/core/itoa_back.sv -----
module itoa_back
   import itoa_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         empty,
   input  logic [VALUE_WIDTH+RADIX_W:0] pop_data,
   output logic                         pop,
   output logic                         rsp_strobe,
   output logic [7:0]                   rsp_character,
   output logic                         rsp_last
);

   localparam int CHUNKS      = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_W       = CHUNKS * DIV_STEPS;
   localparam int CHUNK_CW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int DIGIT_DEPTH = VALUE_WIDTH;
   localparam int DIGIT_AW    = $clog2(DIGIT_DEPTH);

   back_state_type         state_ff, state_in;
   logic [DIV_W-1:0]       work_ff, work_in;
   logic [RADIX_W-1:0]     rem_ff, rem_in;
   logic [RADIX_W-1:0]     base_ff, base_in;
   logic                   neg_ff, neg_in;
   logic [CHUNK_CW-1:0]    chunk_ff, chunk_in;
   logic [DIGIT_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [DIGIT_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic                   rd_last_ff, rd_last_in;
   logic [RADIX_W-1:0]     rd_data_ff;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [DIV_W-1:0]       div_work;
   logic [RADIX_W-1:0]     div_rem;
   logic                   mem_we, mem_re, sign_fire;
   logic [VALUE_WIDTH-1:0] pop_mag;
   logic                   pop_neg;
   logic [RADIX_W-1:0]     pop_base;
   logic [RADIX_W-1:0]     digit_mem [DIGIT_DEPTH];

   assign {pop_mag, pop_neg, pop_base} = pop_data;

   // Divider logic: restoring long division, several dividend bits per cycle.
   // The quotient shifts into the low end of the work word as the dividend leaves.
   always_comb begin
      logic [RADIX_W:0]   part;
      logic [DIV_W-1:0]   w;
      logic [RADIX_W-1:0] r;
      w = work_ff;
      r = rem_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         part = {r, w[DIV_W-1]};
         w    = {w[DIV_W-2:0], 1'b0};
         if (part >= {1'b0, base_ff}) begin
            part = part - {1'b0, base_ff};
            w[0] = 1'b1;
         end
         r = part[RADIX_W-1:0];
      end
      div_work = w;
      div_rem  = r;
   end

   // Sequencer: load, divide digit by digit, optional sign, then read back.
   always_comb begin
      state_in  = state_ff;
      work_in   = work_ff;
      rem_in    = rem_ff;
      base_in   = base_ff;
      neg_in    = neg_ff;
      chunk_in  = chunk_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      pop       = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      sign_fire = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               work_in   = DIV_W'(pop_mag);
               rem_in    = '0;
               base_in   = pop_base;
               neg_in    = pop_neg;
               chunk_in  = '0;
               wr_ptr_in = '0;
               state_in  = B_DIVIDE;
            end
         end
         B_DIVIDE: begin
            work_in  = div_work;
            rem_in   = div_rem;
            chunk_in = chunk_ff + 1'b1;
            if (chunk_ff == CHUNK_CW'(CHUNKS - 1)) begin
               // Digit complete: store the remainder, go on with the quotient.
               mem_we   = 1'b1;
               chunk_in = '0;
               rem_in   = '0;
               if (div_work == '0) begin
                  rd_ptr_in = wr_ptr_ff;
                  state_in  = B_SIGN;
               end else begin
                  wr_ptr_in = wr_ptr_ff + 1'b1;
               end
            end
         end
         B_SIGN: begin
            sign_fire = neg_ff;
            state_in  = B_EMIT;
         end
         B_EMIT: begin
            // Digits were stored least significant first; read them back in reverse.
            mem_re    = 1'b1;
            rd_ptr_in = rd_ptr_ff - 1'b1;
            if (rd_ptr_ff == '0) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Output stage is fed either by the sign or by a digit read in the cycle before.
   assign rd_pend_in    = mem_re;
   assign rd_last_in    = mem_re && (rd_ptr_ff == '0);
   assign rsp_strobe_in = sign_fire || rd_pend_ff;
   assign rsp_char_in   = sign_fire ? CHAR_MINUS : digit_char(rd_data_ff);
   assign rsp_last_in   = !sign_fire && rd_pend_ff && rd_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         rd_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rem_ff      <= rem_in;
      base_ff     <= base_in;
      neg_ff      <= neg_in;
      chunk_ff    <= chunk_in;
      wr_ptr_ff   <= wr_ptr_in;
      rd_ptr_ff   <= rd_ptr_in;
      rd_last_ff  <= rd_last_in;
      rsp_char_ff <= rsp_char_in;
   end

   // Digit store with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[wr_ptr_ff] <= div_rem;
      end
      if (mem_re) begin
         rd_data_ff <= digit_mem[rd_ptr_ff];
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ----- rtl/core/integer_to_ascii_any_base_core.sv -----
// Channel   | Ports                                   | Transfer
// ----------+-----------------------------------------+-------------------------------
// request   | start, busy, req_value                  | start high while busy low
// response  | rsp_strobe, rsp_character, rsp_last     | strobe high for one cycle
// register  | csr_valid, csr_ready, csr_radix         | valid and ready both high
//
// For each item the back end loads it, runs the divider over the whole word once per digit
// (eight dividend bits per cycle), spends a sign step, then reads the digits back; the
// divider loop sets the pace, and the last character leaves through the read data and
// output registers after the last read.
// A two-entry queue lets up to two further items be taken while one converts.
// Reset is synchronous and restores base ten; the digit store is not cleared.
// The receiver cannot stall: each character is shown for exactly one cycle.
module integer_to_ascii_any_base_core
   import itoa_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_strobe,
   output logic [7:0]             rsp_character,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [RADIX_W-1:0]     csr_radix
);

   localparam int ENTRY_W = VALUE_WIDTH + RADIX_W + 1;

   logic               push, full, pop, empty;
   logic [ENTRY_W-1:0] push_data, pop_data;

   // Front end: radix register, sign handling, magnitude.
   itoa_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_value (req_value),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_radix (csr_radix),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   // Queue of classified items.
   itoa_queue #(
      .WIDTH(ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   // Back end: digit division and character output.
   itoa_back #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (empty),
      .pop_data      (pop_data),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- rtl/core/itoa_checker.sv -----
module itoa_checker
   import itoa_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_strobe,
   input logic [7:0] rsp_character,
   input logic       rsp_last,
   input logic       csr_ready
);

   // The last flag is only raised together with a character.
   assert property (@(posedge clock) disable iff (reset) rsp_last |-> rsp_strobe)
      else $error("last flag without a character");

   // Every character is a digit, a lower-case letter or the minus sign.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_character >= CHAR_ZERO && rsp_character <= CHAR_NINE) ||
                      (rsp_character >= CHAR_LOWER_A && rsp_character <= CHAR_LOWER_Z) ||
                      (rsp_character == CHAR_MINUS)))
      else $error("character outside the digit alphabet");

   // A minus sign is always followed by at least one digit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_character == CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign flagged as last");

   // The first digit follows the minus sign after a gap left by the registered digit read.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_character == CHAR_MINUS) |=>
         !rsp_strobe ##1 (rsp_strobe && rsp_character != CHAR_MINUS))
      else $error("minus sign not followed by a digit");

   // The radix register never holds off a write.
   assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("register port not ready");

endmodule

bind integer_to_ascii_any_base_core itoa_checker u_itoa_checker (.*);

// ----- tb/tb.sv -----
module tb
   import itoa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW = VALUE_WIDTH_DEFAULT;
   localparam int STALL_LIMIT = 3000;
   localparam int ITEMS_PER_PHASE = 38;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } char_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [VW-1:0]      req_value = '0;
   logic               rsp_strobe;
   logic [7:0]         rsp_character;
   logic               rsp_last;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [RADIX_W-1:0] csr_radix = '0;

   // Characters still owed by the block, oldest first.
   char_item_type      expected_chars[$];
   char_item_type      owed_char;
   logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
   bit                 gaps_enabled = 1'b1;
   int                 failures = 0;
   int                 stall_cycles = 0;

   integer_to_ascii_any_base_core #(
      .VALUE_WIDTH(VW)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_radix    (csr_radix)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Works out the text of one value in the current base and queues its characters.
   function automatic void predict_text(input logic [VW-1:0] value);
      logic [VW-1:0] word;
      logic [VW-1:0] base;
      logic [VW-1:0] digit;
      logic [7:0]    code;
      logic [7:0]    digits[$];
      char_item_type entry;
      if (radix_setting < RADIX_MIN) begin
         base = VW'(RADIX_MIN);
      end else if (radix_setting > RADIX_MAX) begin
         base = VW'(RADIX_MAX);
      end else begin
         base = VW'(radix_setting);
      end
      word = value;
      if (word == '0) begin
         entry.character = CHAR_ZERO;
         entry.last = 1'b1;
         expected_chars.push_back(entry);
         return;
      end
      // Only base ten prints a sign; the magnitude is taken as an unsigned word.
      if (base == VW'(DECIMAL_BASE) && word[VW-1]) begin
         entry.character = CHAR_MINUS;
         entry.last = 1'b0;
         expected_chars.push_back(entry);
         word = -word;
      end
      while (word != '0) begin
         digit = word % base;
         if (digit > 9) begin
            code = CHAR_LOWER_A + 8'(digit - 10);
         end else begin
            code = CHAR_ZERO + 8'(digit);
         end
         digits.push_front(code);
         word = word / base;
      end
      foreach (digits[i]) begin
         entry.character = digits[i];
         entry.last = (i == digits.size() - 1);
         expected_chars.push_back(entry);
      end
   endfunction

   // Back-to-back items half the time, else mostly short gaps and a few long ones.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if (!gaps_enabled || roll < 10) begin
         return 0;
      end else if (roll < 18) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Spreads values over zero, extremes, small and small negative numbers, powers of two and random words.
   function automatic logic [VW-1:0] pick_value();
      logic [VW-1:0] value;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: value = $urandom;
         4: value = $urandom_range(0, 40);
         5: value = -VW'($urandom_range(1, 1000));
         6: value = '0;
         7: begin
            if ($urandom_range(0, 1)) begin
               value = {1'b1, {(VW-1){1'b0}}} + VW'($urandom_range(0, 3));
            end else begin
               value = {1'b0, {(VW-1){1'b1}}} - VW'($urandom_range(0, 3));
            end
         end
         8: value = VW'(1) << $urandom_range(0, VW - 1);
         default: value = $urandom >> $urandom_range(0, VW - 1);
      endcase
      return value;
   endfunction

   // Offers one item and returns at the falling edge after it is taken,
   // with start still high so the next item can follow without a gap.
   task automatic send_value(input logic [VW-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_value = value;
      do begin
         @(posedge clock);
      end while (busy);
      predict_text(value);
      @(negedge clock);
   endtask

   // Stops offering items and waits for every owed character.
   task automatic drain_results();
      start = 1'b0;
      while (expected_chars.size() != 0) @(negedge clock);
   endtask

   // Changes the base once the block has gone quiet.
   task automatic write_radix(input logic [RADIX_W-1:0] setting);
      drain_results();
      repeat (20) @(negedge clock);
      csr_valid = 1'b1;
      csr_radix = setting;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      radix_setting = setting;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Base ten straight after reset: zero, sign handling and both integer limits.
   task automatic test_decimal_text();
      send_value('0);
      send_value(VW'(1));
      send_value('1);
      send_value({1'b1, {(VW-1){1'b0}}});
      send_value({1'b0, {(VW-1){1'b1}}});
      send_value(-VW'(9));
   endtask

   // Extreme bases, base sixteen and out-of-range register values that clamp to them.
   task automatic test_radix_extremes();
      write_radix(RADIX_MIN);
      send_value('1);
      send_value({1'b1, {(VW-1){1'b0}}});
      write_radix(RADIX_MAX);
      send_value(VW'(35));
      send_value(VW'(36));
      send_value('1);
      write_radix(6'd16);
      send_value(32'hDEAD_BEEF);
      send_value(VW'(10));
      write_radix(6'd0);
      send_value(VW'(5));
      write_radix(6'd1);
      send_value(VW'(2));
      write_radix(6'd63);
      send_value(VW'(35));
      write_radix(6'd37);
      send_value(VW'(71));
      send_value('0);
   endtask

   // Random values over several bases, one phase without gaps and one full drain.
   task automatic test_random_text();
      logic [RADIX_W-1:0] phase_radix[8];
      phase_radix = '{RADIX_MIN, RADIX_MAX, DECIMAL_BASE, 6'd0, 6'd63,
                      RADIX_W'($urandom_range(2, 36)), 6'd16,
                      RADIX_W'($urandom_range(0, 63))};
      foreach (phase_radix[p]) begin
         write_radix(phase_radix[p]);
         gaps_enabled = (p != 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 5 && n == ITEMS_PER_PHASE / 2) begin
               drain_results();
            end
            send_value(pick_value());
         end
      end
      gaps_enabled = 1'b1;
   endtask

   // Each strobed character is checked against the oldest owed one.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_chars.size() == 0) begin
            $error("character %h arrived with nothing owed", rsp_character);
            failures++;
         end else begin
            owed_char = expected_chars.pop_front();
            if (rsp_character !== owed_char.character) begin
               $error("character: expected %h, got %h", owed_char.character, rsp_character);
               failures++;
            end
            if (rsp_last !== owed_char.last) begin
               $error("last: expected %b, got %b", owed_char.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // Ends the run if nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_decimal_text();
      test_radix_extremes();
      test_random_text();
      drain_results();
      repeat (200) @(negedge clock);
      if (expected_chars.size() != 0) begin
         $error("%0d characters never arrived", expected_chars.size());
         failures++;
      end
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/itoa_pkg.sv
rtl/core/itoa_queue.sv
rtl/core/itoa_front.sv
rtl/core/itoa_back.sv
rtl/core/integer_to_ascii_any_base_core.sv
rtl/core/itoa_checker.sv
tb/tb.sv
